FILE: hdl/uhr_pkg.sv
// ----------------------------------------------------------------------------
// uhr_pkg
// Shared sizes, codes and types of the undo history ring.
// ----------------------------------------------------------------------------
package uhr_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int BOARD_BYTES   = 49;

    localparam int HIST_ENTRIES = HISTORY_DEPTH * BOARD_BYTES;
    localparam int HADDR_W      = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;
    localparam int POS_W        = (BOARD_BYTES > 1) ? $clog2(BOARD_BYTES) : 1;
    localparam int TOP_W        = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W      = $clog2(HISTORY_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_UNDO  = 2'd2;

    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_STORED = 2'd1,
        ST_DUP    = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_DECIDE,
        S_COPY,
        S_RESULT,
        S_UNDO
    } state_t;

    typedef struct packed {
        logic               we;
        logic [HADDR_W-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HADDR_W-1:0] raddr;
    } hist_req_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [POS_W-1:0] raddr;
    } stage_req_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic       eor;
        logic [7:0] held;
    } result_t;

endpackage

FILE: hdl/uhr_ram.sv
// ----------------------------------------------------------------------------
// uhr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/uhr_ctrl.sv
// ----------------------------------------------------------------------------
// uhr_ctrl
// Sequencer of the undo history ring: push compare, padding, commit copy and
// undo readout over the history and staging memories.
// ----------------------------------------------------------------------------
module uhr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [7:0]          board_byte,
    input  logic                last,
    input  logic                out_free,
    output logic                res_load,
    output uhr_pkg::result_t    res,
    output uhr_pkg::hist_req_t  hist_req,
    input  logic [7:0]          hist_rdata,
    output uhr_pkg::stage_req_t stage_req,
    input  logic [7:0]          stage_rdata
);

    uhr_pkg::state_t             state_reg, state_next;
    logic [uhr_pkg::TOP_W-1:0]   top_reg, top_next;
    logic [uhr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [uhr_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        differs_reg, differs_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [7:0]                  cmp_byte_reg, cmp_byte_next;
    uhr_pkg::status_t            res_status_reg, res_status_next;

    logic [uhr_pkg::TOP_W-1:0]   prev_slot;
    logic [uhr_pkg::TOP_W-1:0]   top_inc;
    logic [uhr_pkg::HADDR_W-1:0] prev_base;
    logic [uhr_pkg::HADDR_W-1:0] top_base;
    logic [uhr_pkg::HADDR_W-1:0] pos_ext;
    logic [uhr_pkg::POS_W-1:0]   pos_inc;
    logic                        pos_last;
    logic                        empty;
    logic                        cmp_hit;
    logic                        differs_now;

    // The newest entry sits one slot below the top, wrapping below slot zero.
    assign prev_slot = (top_reg == '0) ? uhr_pkg::TOP_W'(uhr_pkg::HISTORY_DEPTH - 1)
                                       : top_reg - uhr_pkg::TOP_W'(1);
    assign top_inc   = (top_reg == uhr_pkg::TOP_W'(uhr_pkg::HISTORY_DEPTH - 1))
                       ? '0 : top_reg + uhr_pkg::TOP_W'(1);
    assign prev_base = uhr_pkg::HADDR_W'(prev_slot)
                       * uhr_pkg::HADDR_W'(uhr_pkg::BOARD_BYTES);
    assign top_base  = uhr_pkg::HADDR_W'(top_reg)
                       * uhr_pkg::HADDR_W'(uhr_pkg::BOARD_BYTES);
    assign pos_ext   = uhr_pkg::HADDR_W'(pos_reg);
    assign pos_inc   = pos_reg + uhr_pkg::POS_W'(1);
    assign pos_last  = (pos_reg == uhr_pkg::POS_W'(uhr_pkg::BOARD_BYTES - 1));
    assign empty     = (count_reg == '0);

    // The compare issued in the previous cycle resolves against the read data now.
    assign cmp_hit     = cmp_valid_reg && (empty || (hist_rdata != cmp_byte_reg));
    assign differs_now = differs_reg || cmp_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= uhr_pkg::S_IDLE;
            top_reg        <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            differs_reg    <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            res_status_reg <= uhr_pkg::ST_DUP;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            differs_reg    <= differs_next;
            cmp_valid_reg  <= cmp_valid_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_byte_reg <= cmp_byte_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        differs_next    = differs_now;
        cmp_valid_next  = 1'b0;
        cmp_byte_next   = cmp_byte_reg;
        res_status_next = res_status_reg;
        in_ready        = 1'b0;
        res_load        = 1'b0;
        res.status      = res_status_reg;
        res.data        = '0;
        res.eor         = 1'b1;
        res.held        = 8'(count_reg);
        hist_req        = '0;
        stage_req       = '0;

        unique case (state_reg)
            uhr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (cmd)
                        uhr_pkg::CMD_CLEAR:
                        begin
                            top_next     = '0;
                            count_next   = '0;
                            pos_next     = '0;
                            differs_next = 1'b0;
                        end
                        uhr_pkg::CMD_PUSH:
                        begin
                            stage_req.we    = 1'b1;
                            stage_req.waddr = pos_reg;
                            stage_req.wdata = board_byte;
                            hist_req.re     = 1'b1;
                            hist_req.raddr  = prev_base + pos_ext;
                            cmp_valid_next  = 1'b1;
                            cmp_byte_next   = board_byte;
                            if (pos_last)
                            begin
                                state_next = uhr_pkg::S_DECIDE;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                                if (last)
                                begin
                                    state_next = uhr_pkg::S_PAD;
                                end
                            end
                        end
                        uhr_pkg::CMD_UNDO:
                        begin
                            pos_next     = '0;
                            differs_next = 1'b0;
                            if (empty)
                            begin
                                res_status_next = uhr_pkg::ST_EMPTY;
                                state_next      = uhr_pkg::S_RESULT;
                            end
                            else
                            begin
                                count_next     = count_reg - uhr_pkg::COUNT_W'(1);
                                top_next       = prev_slot;
                                hist_req.re    = 1'b1;
                                hist_req.raddr = prev_base;
                                state_next     = uhr_pkg::S_UNDO;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            uhr_pkg::S_PAD:
            begin
                stage_req.we    = 1'b1;
                stage_req.waddr = pos_reg;
                stage_req.wdata = '0;
                hist_req.re     = 1'b1;
                hist_req.raddr  = prev_base + pos_ext;
                cmp_valid_next  = 1'b1;
                cmp_byte_next   = '0;
                if (pos_last)
                begin
                    state_next = uhr_pkg::S_DECIDE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            uhr_pkg::S_DECIDE:
            begin
                pos_next     = '0;
                differs_next = 1'b0;
                if (empty || differs_now)
                begin
                    stage_req.re    = 1'b1;
                    stage_req.raddr = '0;
                    state_next      = uhr_pkg::S_COPY;
                end
                else
                begin
                    res_status_next = uhr_pkg::ST_DUP;
                    state_next      = uhr_pkg::S_RESULT;
                end
            end

            uhr_pkg::S_COPY:
            begin
                hist_req.we    = 1'b1;
                hist_req.waddr = top_base + pos_ext;
                hist_req.wdata = stage_rdata;
                if (pos_last)
                begin
                    pos_next        = '0;
                    top_next        = top_inc;
                    if (count_reg != uhr_pkg::COUNT_W'(uhr_pkg::HISTORY_DEPTH))
                    begin
                        count_next = count_reg + uhr_pkg::COUNT_W'(1);
                    end
                    res_status_next = uhr_pkg::ST_STORED;
                    state_next      = uhr_pkg::S_RESULT;
                end
                else
                begin
                    stage_req.re    = 1'b1;
                    stage_req.raddr = pos_inc;
                    pos_next        = pos_inc;
                end
            end

            uhr_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = uhr_pkg::S_IDLE;
                end
            end

            uhr_pkg::S_UNDO:
            begin
                res.status = uhr_pkg::ST_BYTE;
                res.data   = hist_rdata;
                res.eor    = pos_last;
                // The read data register holds while the output side stalls.
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (pos_last)
                    begin
                        pos_next   = '0;
                        state_next = uhr_pkg::S_IDLE;
                    end
                    else
                    begin
                        hist_req.re    = 1'b1;
                        hist_req.raddr = top_base + uhr_pkg::HADDR_W'(pos_inc);
                        pos_next       = pos_inc;
                    end
                end
            end

            default:
            begin
                state_next = uhr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/undo_history_ring_core.sv
// ----------------------------------------------------------------------------
// undo_history_ring_core
// Bounded undo history of fixed-size board snapshots kept in a memory ring.
// ----------------------------------------------------------------------------
// A snapshot is pushed one board byte per transaction (command push) and is
// taken at one byte per cycle; each byte goes into a staging memory while the
// byte at the same place of the newest stored entry is read back from the
// history memory and compared in the following cycle. The final byte (last
// set, or the BOARD_BYTES-th byte) starts a sequence during which no
// transaction is accepted: the rest of a short snapshot is padded with zero
// bytes and compared, a decide step follows, and a snapshot that differs
// from the newest entry, or arrives on an empty history, is copied from
// staging into the ring byte by byte through the single write port of the
// history memory; then one result (stored or duplicate) is presented. An
// undo first issues the read of the first byte and then streams BOARD_BYTES
// restored bytes at one per cycle when the output side keeps up, limited by
// the one read port of the history memory; an undo on an empty history
// gives one result. Clear empties the history and gives no result. Command
// code 3 is ignored. The history memory holds HISTORY_DEPTH slots of
// BOARD_BYTES bytes; when full, the oldest entry is overwritten. The result
// sits in an output register, so the next transaction can be accepted while
// a result still waits to be taken. No memory is cleared after reset; reads
// of unwritten entries (the compare on an empty history) are ignored.
// ----------------------------------------------------------------------------
module undo_history_ring_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] board_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] restored_byte,
    output logic       end_of_run,
    output logic [7:0] entries_held
);

    uhr_pkg::hist_req_t  hist_req;
    uhr_pkg::stage_req_t stage_req;
    logic [7:0]          hist_rdata;
    logic [7:0]          stage_rdata;
    logic                out_free;
    logic                res_load;
    uhr_pkg::result_t    res;
    logic                out_valid_reg;
    uhr_pkg::result_t    res_reg;

    // Ring of snapshots: slot times BOARD_BYTES plus byte position.
    uhr_ram #(
        .WIDTH (8),
        .DEPTH (uhr_pkg::HIST_ENTRIES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_req.we),
        .waddr (hist_req.waddr),
        .wdata (hist_req.wdata),
        .re    (hist_req.re),
        .raddr (hist_req.raddr),
        .rdata (hist_rdata)
    );

    // Staging board for the snapshot being pushed.
    uhr_ram #(
        .WIDTH (8),
        .DEPTH (uhr_pkg::BOARD_BYTES)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stage_req.we),
        .waddr (stage_req.waddr),
        .wdata (stage_req.wdata),
        .re    (stage_req.re),
        .raddr (stage_req.raddr),
        .rdata (stage_rdata)
    );

    uhr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .board_byte  (board_byte),
        .last        (last),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .hist_req    (hist_req),
        .hist_rdata  (hist_rdata),
        .stage_req   (stage_req),
        .stage_rdata (stage_rdata)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign restored_byte = res_reg.data;
    assign end_of_run    = res_reg.eor;
    assign entries_held  = res_reg.held;

    // Only restored bytes can be followed by more results of the same undo.
    a_mid_run_is_byte : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_run) |-> (status == uhr_pkg::ST_BYTE)
    ) else $error("non-final result with a status other than restored byte");

    // While an undo readout is unfinished, no new transaction is accepted.
    a_no_accept_mid_run : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_run) |-> !in_ready
    ) else $error("input accepted during an undo readout");

    // An empty undo reports an empty history.
    a_empty_has_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status == uhr_pkg::ST_EMPTY)) |-> (entries_held == 8'd0)
    ) else $error("empty undo reported with entries held");

endmodule

FILE: verif/undo_history_ring_core_test.sv
// ----------------------------------------------------------------------------
// undo_history_ring_core_test
// Self-checking testbench for the undo history ring core.
// ----------------------------------------------------------------------------
// Every accepted transaction is fed to a behavioral copy of the undo history,
// which queues the results the block has to return. Each returned result is
// checked field by field against the oldest queued result. The run starts
// with a table of hand-picked commands and then sends random command
// sequences: it fills the ring past its depth, walks the newest slot down
// through slot zero, and mixes short, full-length, repeated and abandoned
// snapshots with undo, clear and unused commands. Both sides of the block
// idle at random, but for one stretch of a long hold-off and no random idling.
// ----------------------------------------------------------------------------
module undo_history_ring_core_test;

    // Command code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 260;
    // Enough one-byte snapshots to run the ring past its depth and wrap it.
    localparam int FILL_BOARDS   = uhr_pkg::HISTORY_DEPTH + 4;
    localparam int IDLE_PCT      = 22;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 4 * uhr_pkg::BOARD_BYTES;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_N    = 24;

    // One row of the directed table. Where typed is set, the single result
    // of the row is written out by hand; elsewhere the predictor decides.
    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data;
        logic             fin;
        logic             typed;
        uhr_pkg::status_t want_status;
        logic [7:0]       want_held;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // undo with nothing stored
        '{uhr_pkg::CMD_UNDO, 8'h00, 1'b0, 1'b1, uhr_pkg::ST_EMPTY, 8'd0},
        // unused code, no result
        '{CMD_UNUSED, 8'hAA, 1'b1, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // one-byte board, padded
        '{uhr_pkg::CMD_PUSH, 8'hFF, 1'b1, 1'b1, uhr_pkg::ST_STORED, 8'd1},
        // same board again
        '{uhr_pkg::CMD_PUSH, 8'hFF, 1'b1, 1'b1, uhr_pkg::ST_DUP, 8'd1},
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h80, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h7F, 1'b1, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h80, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // three-byte board repeated
        '{uhr_pkg::CMD_PUSH, 8'h7F, 1'b1, 1'b1, uhr_pkg::ST_DUP, 8'd2},
        // streams the full board
        '{uhr_pkg::CMD_UNDO, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h55, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // abandons the push above
        '{uhr_pkg::CMD_UNDO, 8'hFF, 1'b1, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_UNDO, 8'h00, 1'b0, 1'b1, uhr_pkg::ST_EMPTY, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'h01, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // clear in mid-push
        '{uhr_pkg::CMD_CLEAR, 8'hFF, 1'b1, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // all-zero board
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b1, 1'b1, uhr_pkg::ST_STORED, 8'd1},
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b1, 1'b1, uhr_pkg::ST_DUP, 8'd1},
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        // padding matches zeros
        '{uhr_pkg::CMD_PUSH, 8'h00, 1'b1, 1'b1, uhr_pkg::ST_DUP, 8'd1},
        '{uhr_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_UNDO, 8'h00, 1'b0, 1'b1, uhr_pkg::ST_EMPTY, 8'd0},
        '{CMD_UNUSED, 8'h00, 1'b0, 1'b0, uhr_pkg::ST_BYTE, 8'd0},
        '{uhr_pkg::CMD_PUSH, 8'hFF, 1'b1, 1'b1, uhr_pkg::ST_STORED, 8'd1}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] cmd;
    logic [7:0] board_byte;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [7:0] restored_byte;
    logic       end_of_run;
    logic [7:0] entries_held;

    // Behavioral copy of the undo history, updated on every accepted command.
    logic [7:0]                  ring_image [uhr_pkg::HIST_ENTRIES];
    logic [7:0]                  staged_board [uhr_pkg::BOARD_BYTES];
    logic [uhr_pkg::TOP_W-1:0]   next_slot;
    logic [uhr_pkg::COUNT_W-1:0] boards_held;
    logic [uhr_pkg::POS_W-1:0]   push_pos;
    logic                        push_differs;

    uhr_pkg::result_t expected_results [$];
    uhr_pkg::result_t step_results [$];

    // Pacing controls shared between the sender and the receiver.
    bit no_idle;
    bit hold_request;
    int hold_left;

    int items_sent;
    int results_checked;
    int mismatches;
    int boards_stored;
    int boards_skipped;
    int bytes_restored;
    int empty_undos;
    int peak_held;
    int cycle_count;

    undo_history_ring_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .board_byte    (board_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .restored_byte (restored_byte),
        .end_of_run    (end_of_run),
        .entries_held  (entries_held)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // History predictor
    // ------------------------------------------------------------------------

    // The newest board sits just below the next free slot, and wraps to the
    // top slot of the ring when the next free slot is zero.
    function automatic int newest_slot();
        return (next_slot == 0) ? uhr_pkg::HISTORY_DEPTH - 1 : int'(next_slot) - 1;
    endfunction

    function automatic uhr_pkg::result_t shaped_result(uhr_pkg::status_t kind,
                                                       logic [7:0] data, logic fin);
        uhr_pkg::result_t res;
        res.status = kind;
        res.data   = data;
        res.eor    = fin;
        res.held   = 8'(boards_held);
        return res;
    endfunction

    task automatic reset_history();
        foreach (ring_image[i])
            ring_image[i] = 8'h00;
        foreach (staged_board[i])
            staged_board[i] = 8'h00;
        next_slot    = '0;
        boards_held  = '0;
        push_pos     = '0;
        push_differs = 1'b0;
    endtask

    // Applies one command to the history and leaves its results in
    // step_results.
    task automatic apply_to_history(input logic [1:0] op, input logic [7:0] data,
                                    input logic fin);
        int pos;
        int prev_base;
        int base;
        int i;
        step_results.delete();
        case (op)
            uhr_pkg::CMD_CLEAR:
            begin
                next_slot    = '0;
                boards_held  = '0;
                push_pos     = '0;
                push_differs = 1'b0;
            end
            uhr_pkg::CMD_PUSH:
            begin
                pos       = int'(push_pos);
                prev_base = newest_slot() * uhr_pkg::BOARD_BYTES;
                if (pos >= uhr_pkg::BOARD_BYTES)
                    pos = 0;
                staged_board[pos] = data;
                if (boards_held == 0 || ring_image[prev_base + pos] != data)
                    push_differs = 1'b1;
                pos++;
                if (!fin && pos < uhr_pkg::BOARD_BYTES)
                begin
                    push_pos = uhr_pkg::POS_W'(pos);
                end
                else
                begin
                    // A board that ends early counts as padded with zero bytes.
                    for (i = pos; i < uhr_pkg::BOARD_BYTES; i++)
                    begin
                        staged_board[i] = 8'h00;
                        if (boards_held == 0 || ring_image[prev_base + i] != 8'h00)
                            push_differs = 1'b1;
                    end
                    push_pos = '0;
                    if (boards_held == 0 || push_differs)
                    begin
                        base = int'(next_slot) * uhr_pkg::BOARD_BYTES;
                        for (i = 0; i < uhr_pkg::BOARD_BYTES; i++)
                            ring_image[base + i] = staged_board[i];
                        next_slot = (int'(next_slot) + 1 >= uhr_pkg::HISTORY_DEPTH) ?
                                    '0 : next_slot + 1'b1;
                        if (boards_held < uhr_pkg::HISTORY_DEPTH)
                            boards_held++;
                        step_results.push_back(
                            shaped_result(uhr_pkg::ST_STORED, 8'h00, 1'b1));
                    end
                    else
                    begin
                        step_results.push_back(
                            shaped_result(uhr_pkg::ST_DUP, 8'h00, 1'b1));
                    end
                    push_differs = 1'b0;
                end
            end
            uhr_pkg::CMD_UNDO:
            begin
                push_pos     = '0;
                push_differs = 1'b0;
                if (boards_held == 0)
                begin
                    step_results.push_back(
                        shaped_result(uhr_pkg::ST_EMPTY, 8'h00, 1'b1));
                end
                else
                begin
                    boards_held--;
                    next_slot = uhr_pkg::TOP_W'(newest_slot());
                    base      = int'(next_slot) * uhr_pkg::BOARD_BYTES;
                    for (i = 0; i < uhr_pkg::BOARD_BYTES; i++)
                        step_results.push_back(
                            shaped_result(uhr_pkg::ST_BYTE, ring_image[base + i],
                                          i == uhr_pkg::BOARD_BYTES - 1));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one command, waits for the transaction, then books the results
    // it causes. A typed result from the directed table replaces the
    // predicted one.
    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic fin,
                             input logic typed = 1'b0,
                             input uhr_pkg::result_t typed_result = '0);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        board_byte <= data;
        last       <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        apply_to_history(op, data, fin);
        if (typed)
            expected_results.push_back(typed_result);
        else
            foreach (step_results[k])
                expected_results.push_back(step_results[k]);
        if (op != CMD_UNUSED)
            items_sent++;
    endtask

    // Drops valid and waits until every booked result has been returned.
    // At least one edge passes, so valid is never lowered and raised again
    // within the same time step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Pushes the newest stored board again, either closed by last or sent at
    // full length with last low. With tweak set one bit is flipped, so the
    // board differs from the stored one by a single byte.
    task automatic repush_newest(input bit tweak);
        int         base;
        int         len;
        int         count;
        int         spot;
        int         i;
        bit         full_length;
        logic [7:0] image [uhr_pkg::BOARD_BYTES];
        base = newest_slot() * uhr_pkg::BOARD_BYTES;
        len  = 1;
        for (i = 0; i < uhr_pkg::BOARD_BYTES; i++)
        begin
            image[i] = ring_image[base + i];
            if (image[i] != 8'h00)
                len = i + 1;
        end
        full_length = $urandom_range(1);
        count       = full_length ? uhr_pkg::BOARD_BYTES : len;
        spot        = tweak ? $urandom_range(count - 1) : -1;
        for (i = 0; i < count; i++)
        begin
            if (i == spot)
                image[i] = image[i] ^ 8'(1 << $urandom_range(7));
            send_item(uhr_pkg::CMD_PUSH, image[i], !full_length && i == count - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and result checking
    // ------------------------------------------------------------------------

    // out_ready idles at random unless a long hold-off is running. The hold
    // is counted here so that the sender keeps offering commands meanwhile.
    always @(posedge clk)
    begin : result_check
        uhr_pkg::result_t want;
        if (hold_request && hold_left == 0)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d byte %02h end %0b held %0d",
                             status, restored_byte, end_of_run, entries_held);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || restored_byte !== want.data ||
                    end_of_run !== want.eor || entries_held !== want.held)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result %0d mismatch: expected status %0d byte %02h ",
                                  "end %0b held %0d, got status %0d byte %02h end %0b held %0d"},
                                 results_checked, want.status, want.data, want.eor, want.held,
                                 status, restored_byte, end_of_run, entries_held);
                end
                results_checked++;
                case (want.status)
                    uhr_pkg::ST_BYTE:   bytes_restored++;
                    uhr_pkg::ST_STORED: boards_stored++;
                    uhr_pkg::ST_DUP:    boards_skipped++;
                    default:            empty_undos++;
                endcase
                if (int'(want.held) > peak_held)
                    peak_held = int'(want.held);
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int               r;
        int               n;
        int               i;
        int               pick;
        int               random_start;
        logic [7:0]       data;
        logic [7:0]       prev_byte;
        uhr_pkg::result_t fixed;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = uhr_pkg::CMD_CLEAR;
        board_byte   = 8'h00;
        last         = 1'b0;
        out_ready    = 1'b0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        reset_history();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty history, duplicates, short and all-zero boards,
        // interrupted pushes, clear and the unused command code.
        for (r = 0; r < DIRECTED_N; r++)
        begin
            fixed = shaped_result(DIRECTED_ROWS[r].want_status, 8'h00, 1'b1);
            fixed.held = DIRECTED_ROWS[r].want_held;
            send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].fin,
                      DIRECTED_ROWS[r].typed, fixed);
        end
        wait_drained();
        random_start = items_sent;

        // Fill the ring past its depth with one-byte boards, each differing from the
        // one before, with no random idling on either side. The receiver holds off
        // for a long stretch at the start, so the block backs up and stalls its input.
        no_idle      = 1'b1;
        hold_request = 1'b1;
        prev_byte    = ring_image[newest_slot() * uhr_pkg::BOARD_BYTES];
        for (n = 0; n < FILL_BOARDS; n++)
        begin
            do
                data = 8'($urandom);
            while (data == prev_byte);
            send_item(uhr_pkg::CMD_PUSH, data, 1'b1);
            prev_byte = data;
        end
        no_idle = 1'b0;
        // Pause here until the backlog has been returned.
        wait_drained();

        // Undo down to slot zero, so the newest board wraps to the top slot,
        // then repeat that board and undo across the wrap.
        while (next_slot != 0 && boards_held != 0)
            send_item(uhr_pkg::CMD_UNDO, 8'($urandom), 1'($urandom));
        if (boards_held != 0)
            repush_newest(1'b0);
        send_item(uhr_pkg::CMD_UNDO, 8'h00, 1'b0);

        // Random command sequences, mostly well formed, with some noise.
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                n = $urandom_range(8, 1);
                for (i = 0; i < n; i++)
                    send_item(uhr_pkg::CMD_PUSH, 8'($urandom), i == n - 1);
            end
            else if (pick < 36)
            begin
                // Full-length board; with last low the length alone ends it.
                for (i = 0; i < uhr_pkg::BOARD_BYTES; i++)
                    send_item(uhr_pkg::CMD_PUSH, 8'($urandom),
                              i == uhr_pkg::BOARD_BYTES - 1 && $urandom_range(1));
            end
            else if (pick < 52)
            begin
                if (boards_held != 0)
                    repush_newest($urandom_range(99) < 35);
                else
                    send_item(uhr_pkg::CMD_UNDO, 8'($urandom), 1'($urandom));
            end
            else if (pick < 70)
            begin
                send_item(uhr_pkg::CMD_UNDO, 8'($urandom), 1'($urandom));
            end
            else if (pick < 80)
            begin
                // A push cut short by undo or clear.
                n = $urandom_range(10, 1);
                for (i = 0; i < n; i++)
                    send_item(uhr_pkg::CMD_PUSH, 8'($urandom), 1'b0);
                send_item(($urandom_range(3) == 0) ? uhr_pkg::CMD_CLEAR : uhr_pkg::CMD_UNDO,
                          8'($urandom), 1'($urandom));
            end
            else if (pick < 83)
            begin
                send_item(uhr_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
            end
            else if (pick < 90)
            begin
                send_item(CMD_UNUSED, 8'($urandom), 1'($urandom));
            end
            else
            begin
                send_item(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end

        wait_drained();
        // Any late or extra result would show up as unexpected in this window.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d results checked: %0d boards stored, %0d skipped",
                 items_sent, results_checked, boards_stored, boards_skipped);
        $display("%0d bytes restored, %0d undos on an empty history, up to %0d boards held",
                 bytes_restored, empty_undos, peak_held);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hdl/uhr_pkg.sv
hdl/uhr_ram.sv
hdl/uhr_ctrl.sv
hdl/undo_history_ring_core.sv
verif/undo_history_ring_core_test.sv
